FILE: rtl/pf3_pkg.sv
// Shared types, constants and cell commands of the 3-D Pareto stream filter.
package pf3_pkg;

  localparam int STAIR_DEPTH = 64;
  localparam int COORD_WIDTH = 32;
  localparam int MAX_SET     = 65536;
  localparam int POS_WIDTH   = 16;
  localparam int KEPT_WIDTH  = 17;
  localparam int CFG_IDX_WIDTH = 1;

  localparam logic [POS_WIDTH:0] POS_WRAP = (POS_WIDTH + 1)'(MAX_SET);
  localparam logic [KEPT_WIDTH-1:0] KEPT_CAP =
    KEPT_WIDTH'((MAX_SET < 131071) ? MAX_SET : 131071);

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_KEEP_DUP   = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_STOP_FIRST = CFG_IDX_WIDTH'(1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t coord_x;
    coord_t coord_y;
    coord_t coord_z;
    logic   first_in_set;
    logic   last_in_set;
  } in_word_t;

  typedef struct packed {
    logic                  is_dominated;
    logic [POS_WIDTH-1:0]  item_position;
    logic [KEPT_WIDTH-1:0] kept_count;
    logic                  skipped;
    logic                  front_overflow;
    logic                  set_done;
  } out_word_t;

  typedef struct packed {
    logic   vld;
    logic   hole;
    coord_t x;
    coord_t y;
  } entry_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_REPLACE,
    OP_INSERT,
    OP_COMPACT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    coord_t   x;
    coord_t   y;
  } cell_cmd_t;

  typedef struct packed {
    logic dom;
    logic any_del;
    logic full;
    logic busy;
  } stair_stat_t;

endpackage

FILE: rtl/pareto_filter_3d_sorted_stream_top.sv
// Top level of the 3-D Pareto stream filter: handshakes, set counters and control.
//
//   channel  direction  handshake                   payload
//   in       input      in_valid_i / in_stall_o     in_word_i (pf3_pkg::in_word_t)
//   out      output     out_valid_o / out_stall_i   out_word_o (pf3_pkg::out_word_t)
//   cfg      input      cfg_we_i                    cfg_idx_i, cfg_data_i
//
// A word is registered on acceptance and then decided against all cells at once.
// A kept point that removes staircase entries leaves holes, which the cell chain closes
// one entry per cycle; otherwise one word is taken every cycle while the output is not stalled.
// Reset empties the staircase at once and clears the counters and control registers.
// A stalled output holds its word, and the input stalls once the word behind it is waiting.
module pareto_filter_3d_sorted_stream_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  pf3_pkg::in_word_t                    in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output pf3_pkg::out_word_t                   out_word_o,
  input  logic                                 cfg_we_i,
  input  logic [pf3_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx_i,
  input  logic                                 cfg_data_i
);

  localparam logic [pf3_pkg::KEPT_WIDTH-1:0] KEPT_ZERO = '0;
  localparam logic [pf3_pkg::KEPT_WIDTH-1:0] KEPT_ONE  = pf3_pkg::KEPT_WIDTH'(1);

  pf3_pkg::in_word_t    item_q;
  logic                 item_vld_q, item_vld_d;
  pf3_pkg::out_word_t   out_q, out_d;
  logic                 out_vld_q, out_vld_d;
  logic                 keep_dup_q, stop_first_q;

  pf3_pkg::coord_t      lk_x_q, lk_y_q, lk_z_q;
  pf3_pkg::coord_t      lk_x_d, lk_y_d, lk_z_d;
  logic                 prev_dom_q, prev_dom_d;
  logic                 stopped_q, stopped_d;
  logic [pf3_pkg::POS_WIDTH-1:0]  pos_q, pos_d;
  logic [pf3_pkg::KEPT_WIDTH-1:0] kept_q, kept_d;
  logic [pf3_pkg::POS_WIDTH:0]    pos_sum;

  pf3_pkg::cell_cmd_t   cmd;
  pf3_pkg::stair_stat_t stat;
  logic                 exec;
  logic                 accept;
  logic                 better;
  logic                 same;
  logic                 dom;
  logic                 lost;

  assign exec       = item_vld_q && !stat.busy && (!out_vld_q || !out_stall_i);
  assign in_stall_o = item_vld_q && !exec;
  assign accept     = in_valid_i && !in_stall_o;

  assign better  = (lk_x_q > item_q.coord_x) || (lk_y_q > item_q.coord_y);
  assign same    = (lk_x_q == item_q.coord_x) && (lk_y_q == item_q.coord_y) &&
                   (lk_z_q == item_q.coord_z);
  assign pos_sum = {1'b0, pos_q} + 1'b1;

  always_comb begin
    lk_x_d     = lk_x_q;
    lk_y_d     = lk_y_q;
    lk_z_d     = lk_z_q;
    prev_dom_d = prev_dom_q;
    stopped_d  = stopped_q;
    pos_d      = pos_q;
    kept_d     = kept_q;
    dom        = 1'b0;
    lost       = 1'b0;
    cmd.op     = stat.busy ? pf3_pkg::OP_COMPACT : pf3_pkg::OP_HOLD;
    cmd.x      = item_q.coord_x;
    cmd.y      = item_q.coord_y;
    out_d      = out_q;

    if (exec) begin
      if (item_q.first_in_set) begin
        cmd.op     = pf3_pkg::OP_CLEAR;
        lk_x_d     = item_q.coord_x;
        lk_y_d     = item_q.coord_y;
        lk_z_d     = item_q.coord_z;
        prev_dom_d = 1'b0;
        stopped_d  = 1'b0;
        pos_d      = '0;
        kept_d     = (KEPT_ZERO < pf3_pkg::KEPT_CAP) ? KEPT_ONE : KEPT_ZERO;
      end else begin
        pos_d = (pos_sum >= pf3_pkg::POS_WRAP) ? '0 : pos_sum[pf3_pkg::POS_WIDTH-1:0];
        if (!stopped_q) begin
          if (better) begin
            dom  = stat.dom;
            lost = !stat.dom && !stat.any_del && stat.full;
            if (!stat.dom) begin
              priority if (stat.any_del) begin
                cmd.op = pf3_pkg::OP_REPLACE;
              end else if (!stat.full) begin
                cmd.op = pf3_pkg::OP_INSERT;
              end
            end
          end else begin
            dom = !(keep_dup_q && !prev_dom_q && same);
          end
          if (dom) begin
            prev_dom_d = 1'b1;
            if (stop_first_q) begin
              stopped_d = 1'b1;
            end
          end else begin
            lk_x_d     = item_q.coord_x;
            lk_y_d     = item_q.coord_y;
            lk_z_d     = item_q.coord_z;
            prev_dom_d = 1'b0;
            if (kept_q < pf3_pkg::KEPT_CAP) begin
              kept_d = kept_q + 1'b1;
            end
          end
        end
      end
      out_d.is_dominated   = dom;
      out_d.item_position  = pos_d;
      out_d.kept_count     = kept_d;
      out_d.skipped        = !item_q.first_in_set && stopped_q;
      out_d.front_overflow = lost;
      out_d.set_done       = item_q.last_in_set;
    end
  end

  always_comb begin
    item_vld_d = item_vld_q;
    if (accept) begin
      item_vld_d = 1'b1;
    end else if (exec) begin
      item_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (exec) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  pf3_stair u_stair (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
      keep_dup_q   <= 1'b0;
      stop_first_q <= 1'b0;
      lk_x_q       <= '0;
      lk_y_q       <= '0;
      lk_z_q       <= '0;
      prev_dom_q   <= 1'b0;
      stopped_q    <= 1'b0;
      pos_q        <= '0;
      kept_q       <= '0;
    end else begin
      item_vld_q <= item_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pf3_pkg::CFG_KEEP_DUP:   keep_dup_q   <= cfg_data_i;
          pf3_pkg::CFG_STOP_FIRST: stop_first_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      lk_x_q     <= lk_x_d;
      lk_y_q     <= lk_y_d;
      lk_z_q     <= lk_z_d;
      prev_dom_q <= prev_dom_d;
      stopped_q  <= stopped_d;
      pos_q      <= pos_d;
      kept_q     <= kept_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_word_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

FILE: rtl/pf3_cell.sv
// One staircase cell: holds one (x,y) entry and compares it with the broadcast point.
module pf3_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_i,
  input  pf3_pkg::cell_cmd_t cmd_i,
  input  pf3_pkg::entry_t   left_i,
  input  pf3_pkg::entry_t   right_i,
  input  logic              left_le_i,
  input  logic              right_le_i,
  output pf3_pkg::entry_t   entry_o,
  output logic              le_o,
  output logic              dom_o,
  output logic              del_o
);

  logic            vld_q, vld_d;
  logic            hole_q, hole_d;
  logic            tail_q, tail_d;
  pf3_pkg::coord_t x_q, x_d;
  pf3_pkg::coord_t y_q, y_d;
  logic            at_p;
  logic            tail;

  assign le_o  = vld_q && (x_q <= cmd_i.x);
  assign at_p  = !le_o && left_le_i;
  assign tail  = !le_o && !at_p;
  assign dom_o = le_o && !right_le_i && (y_q <= cmd_i.y);
  assign del_o = vld_q && !le_o && (cmd_i.y <= y_q);

  assign entry_o = '{vld: vld_q, hole: hole_q, x: x_q, y: y_q};

  always_comb begin
    vld_d  = vld_q;
    hole_d = hole_q;
    tail_d = tail_q;
    x_d    = x_q;
    y_d    = y_q;
    unique case (cmd_i.op)
      pf3_pkg::OP_HOLD: begin
      end
      pf3_pkg::OP_CLEAR: begin
        vld_d  = head_i;
        hole_d = 1'b0;
        x_d    = cmd_i.x;
        y_d    = cmd_i.y;
      end
      pf3_pkg::OP_REPLACE: begin
        tail_d = tail;
        if (at_p) begin
          vld_d  = 1'b1;
          hole_d = 1'b0;
          x_d    = cmd_i.x;
          y_d    = cmd_i.y;
        end else if (del_o) begin
          vld_d  = 1'b0;
          hole_d = 1'b1;
        end
      end
      pf3_pkg::OP_INSERT: begin
        if (at_p) begin
          vld_d  = 1'b1;
          hole_d = 1'b0;
          x_d    = cmd_i.x;
          y_d    = cmd_i.y;
        end else if (tail) begin
          vld_d  = left_i.vld;
          hole_d = left_i.hole;
          x_d    = left_i.x;
          y_d    = left_i.y;
        end
      end
      pf3_pkg::OP_COMPACT: begin
        if (tail_q) begin
          vld_d  = right_i.vld;
          hole_d = right_i.hole;
          x_d    = right_i.x;
          y_d    = right_i.y;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      hole_q <= 1'b0;
      tail_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      hole_q <= hole_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

endmodule

FILE: rtl/pf3_stair.sv
// Chain of staircase cells with the broadcast status reductions.
module pf3_stair (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pf3_pkg::cell_cmd_t   cmd_i,
  output pf3_pkg::stair_stat_t stat_o
);

  localparam int N = pf3_pkg::STAIR_DEPTH;

  pf3_pkg::entry_t entry [N];
  pf3_pkg::entry_t left  [N];
  pf3_pkg::entry_t right [N];
  logic [N-1:0]    le;
  logic [N-1:0]    left_le;
  logic [N-1:0]    right_le;
  logic [N-1:0]    dom;
  logic [N-1:0]    del;
  logic [N-1:0]    hole;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left[i]    = '0;
      assign left_le[i] = 1'b1;
    end else begin : g_body
      assign left[i]    = entry[i-1];
      assign left_le[i] = le[i-1];
    end
    if (i == N - 1) begin : g_end
      assign right[i]    = '0;
      assign right_le[i] = 1'b0;
    end else begin : g_mid
      assign right[i]    = entry[i+1];
      assign right_le[i] = le[i+1];
    end

    assign hole[i] = entry[i].hole;

    pf3_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .head_i     (i == 0),
      .cmd_i      (cmd_i),
      .left_i     (left[i]),
      .right_i    (right[i]),
      .left_le_i  (left_le[i]),
      .right_le_i (right_le[i]),
      .entry_o    (entry[i]),
      .le_o       (le[i]),
      .dom_o      (dom[i]),
      .del_o      (del[i])
    );
  end

  assign stat_o.dom     = |dom;
  assign stat_o.any_del = |del;
  assign stat_o.full    = entry[N-1].vld;
  assign stat_o.busy    = |hole;

endmodule
